// ----- hdl/qvr_pkg.sv -----
// qvr_pkg: shared types, constants and arithmetic helpers for the quaternion vector rotate unit
// no dependencies; used by the channel interfaces and every module of the block

package qvr_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned PROD_SH = 29;
  localparam int unsigned DPROD_W = PROD_W - PROD_SH;
  localparam int unsigned ESUM_W  = DPROD_W + 2;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned OUT_SH  = 30;
  localparam int unsigned RND_W   = ACC_W - OUT_SH;
  localparam int unsigned Q_FRAC  = 30;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  // doubled product slots
  localparam int unsigned NPROD = 9;
  localparam int unsigned P_XX  = 0;
  localparam int unsigned P_YY  = 1;
  localparam int unsigned P_ZZ  = 2;
  localparam int unsigned P_XY  = 3;
  localparam int unsigned P_XZ  = 4;
  localparam int unsigned P_YZ  = 5;
  localparam int unsigned P_WX  = 6;
  localparam int unsigned P_WY  = 7;
  localparam int unsigned P_WZ  = 8;

  typedef logic signed [DATA_W-1:0]  word_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DPROD_W-1:0] dprod_t;
  typedef logic signed [ESUM_W-1:0]  esum_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [RND_W-1:0]   rnd_t;

  localparam esum_t ONE_Q30   = esum_t'(1) <<< Q_FRAC;
  localparam prod_t HALF_PROD = prod_t'(1) <<< (PROD_SH - 1);
  localparam acc_t  HALF_OUT  = acc_t'(1) <<< (OUT_SH - 1);
  localparam rnd_t  OUT_MAX   = (rnd_t'(1) <<< (DATA_W - 1)) - rnd_t'(1);
  localparam rnd_t  OUT_MIN   = -(rnd_t'(1) <<< (DATA_W - 1));

  typedef struct packed {
    word_t quat_w;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
    word_t vec_x;
    word_t vec_y;
    word_t vec_z;
  } qvr_in_t;

  typedef struct packed {
    word_t rot_x;
    word_t rot_y;
    word_t rot_z;
  } qvr_out_t;

  // rotation matrix row-major plus the vector (x, y, z at index 0, 1, 2)
  typedef struct packed {
    word_t [2:0][2:0] m;
    word_t [2:0]      v;
  } qvr_mat_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              push;
    logic              pop;
  } qvr_qstat_t;

  function automatic prod_t mul_ss(word_t a, word_t b);
    prod_t r;
    r = a * b;
    return r;
  endfunction

  // floor((p + 2^28) / 2^29)
  function automatic dprod_t round_dprod(prod_t p);
    prod_t t;
    t = p + HALF_PROD;
    return dprod_t'(t[PROD_W-1:PROD_SH]);
  endfunction

  function automatic word_t clamp_elem(esum_t s);
    esum_t r;
    if (s > ONE_Q30) begin
      r = ONE_Q30;
    end else if (s < -ONE_Q30) begin
      r = -ONE_Q30;
    end else begin
      r = s;
    end
    return word_t'(r);
  endfunction

  // floor((s + 2^29) / 2^30), then saturate to 32 bits
  function automatic word_t round_sat(acc_t s);
    acc_t t;
    rnd_t q;
    t = s + HALF_OUT;
    q = rnd_t'(t[ACC_W-1:OUT_SH]);
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
    end
    return word_t'(q);
  endfunction

endpackage

// ----- hdl/qvr_ifs.sv -----
// qvr_ifs: valid/ready channel interfaces for input and result words
// depends on qvr_pkg for the payload structs

interface qvr_in_if;
  import qvr_pkg::*;

  logic    valid;
  logic    ready;
  qvr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qvr_out_if;
  import qvr_pkg::*;

  logic     valid;
  logic     ready;
  qvr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/qvr_front.sv -----
// qvr_front: accepts input words and builds the clamped rotation matrix in three stages
// depends on qvr_pkg and qvr_in_if; feeds qvr_queue

module qvr_front (
  input  logic             clk,
  input  logic             rst_n,
  qvr_in_if.sink           in_chan,
  output logic             mat_valid,
  input  logic             mat_ready,
  output qvr_pkg::qvr_mat_t mat_word
);
  import qvr_pkg::*;

  logic rdy1, rdy2, rdy3;
  logic s1_v_r, s2_v_r, s3_v_r;

  prod_t  [NPROD-1:0] s1_p_nxt, s1_p_r;
  word_t  [2:0]       s1_vec_nxt, s1_vec_r;
  dprod_t [NPROD-1:0] s2_d_nxt, s2_d_r;
  word_t  [2:0]       s2_vec_r;
  qvr_mat_t           s3_word_nxt, s3_word_r;

  assign rdy3 = !s3_v_r || mat_ready;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_chan.ready = rdy1;
  assign mat_valid     = s3_v_r;
  assign mat_word      = s3_word_r;

  // quaternion products
  always_comb begin
    s1_p_nxt[P_XX] = mul_ss(in_chan.data.quat_x, in_chan.data.quat_x);
    s1_p_nxt[P_YY] = mul_ss(in_chan.data.quat_y, in_chan.data.quat_y);
    s1_p_nxt[P_ZZ] = mul_ss(in_chan.data.quat_z, in_chan.data.quat_z);
    s1_p_nxt[P_XY] = mul_ss(in_chan.data.quat_x, in_chan.data.quat_y);
    s1_p_nxt[P_XZ] = mul_ss(in_chan.data.quat_x, in_chan.data.quat_z);
    s1_p_nxt[P_YZ] = mul_ss(in_chan.data.quat_y, in_chan.data.quat_z);
    s1_p_nxt[P_WX] = mul_ss(in_chan.data.quat_w, in_chan.data.quat_x);
    s1_p_nxt[P_WY] = mul_ss(in_chan.data.quat_w, in_chan.data.quat_y);
    s1_p_nxt[P_WZ] = mul_ss(in_chan.data.quat_w, in_chan.data.quat_z);
    s1_vec_nxt[0]  = in_chan.data.vec_x;
    s1_vec_nxt[1]  = in_chan.data.vec_y;
    s1_vec_nxt[2]  = in_chan.data.vec_z;
  end

  // doubled products rounded to q1.30
  always_comb begin
    for (int i = 0; i < NPROD; i++) begin
      s2_d_nxt[i] = round_dprod(s1_p_r[i]);
    end
  end

  // matrix elements
  always_comb begin
    s3_word_nxt.v = s2_vec_r;
    s3_word_nxt.m[0][0] = clamp_elem(ONE_Q30 - (esum_t'(s2_d_r[P_YY]) + esum_t'(s2_d_r[P_ZZ])));
    s3_word_nxt.m[0][1] = clamp_elem(esum_t'(s2_d_r[P_XY]) - esum_t'(s2_d_r[P_WZ]));
    s3_word_nxt.m[0][2] = clamp_elem(esum_t'(s2_d_r[P_XZ]) + esum_t'(s2_d_r[P_WY]));
    s3_word_nxt.m[1][0] = clamp_elem(esum_t'(s2_d_r[P_XY]) + esum_t'(s2_d_r[P_WZ]));
    s3_word_nxt.m[1][1] = clamp_elem(ONE_Q30 - (esum_t'(s2_d_r[P_XX]) + esum_t'(s2_d_r[P_ZZ])));
    s3_word_nxt.m[1][2] = clamp_elem(esum_t'(s2_d_r[P_YZ]) - esum_t'(s2_d_r[P_WX]));
    s3_word_nxt.m[2][0] = clamp_elem(esum_t'(s2_d_r[P_XZ]) - esum_t'(s2_d_r[P_WY]));
    s3_word_nxt.m[2][1] = clamp_elem(esum_t'(s2_d_r[P_YZ]) + esum_t'(s2_d_r[P_WX]));
    s3_word_nxt.m[2][2] = clamp_elem(ONE_Q30 - (esum_t'(s2_d_r[P_XX]) + esum_t'(s2_d_r[P_YY])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_chan.valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_chan.valid) begin
      s1_p_r   <= s1_p_nxt;
      s1_vec_r <= s1_vec_nxt;
    end
    if (rdy2 && s1_v_r) begin
      s2_d_r   <= s2_d_nxt;
      s2_vec_r <= s1_vec_r;
    end
    if (rdy3 && s2_v_r) begin
      s3_word_r <= s3_word_nxt;
    end
  end

endmodule

// ----- hdl/qvr_queue.sv -----
// qvr_queue: short fifo of matrix words between the front and back parts
// depends on qvr_pkg for the word and status types

module qvr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  qvr_pkg::qvr_mat_t   push_word,
  output logic                pop_valid,
  input  logic                pop_ready,
  output qvr_pkg::qvr_mat_t   pop_word,
  output qvr_pkg::qvr_qstat_t stat
);
  import qvr_pkg::*;

  qvr_mat_t [QDEPTH-1:0] entry_r;
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                  push, pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_word   = entry_r[rd_ptr_r];

  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  assign stat.level = cnt_r;
  assign stat.push  = push;
  assign stat.pop   = pop;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ----- hdl/qvr_back.sv -----
// qvr_back: matrix times vector, rounding and saturation, with the result output register
// depends on qvr_pkg and qvr_out_if; drains qvr_queue

module qvr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mat_valid,
  output logic              mat_ready,
  input  qvr_pkg::qvr_mat_t mat_word,
  qvr_out_if.source         out_chan
);
  import qvr_pkg::*;

  logic rdy1, rdy2, rdy3;
  logic b1_v_r, b2_v_r, out_v_r;

  prod_t [2:0][2:0] b1_p_nxt, b1_p_r;
  acc_t  [2:0]      b2_s_nxt, b2_s_r;
  qvr_out_t         out_word_nxt, out_word_r;

  assign rdy3 = !out_v_r || out_chan.ready;
  assign rdy2 = !b2_v_r || rdy3;
  assign rdy1 = !b1_v_r || rdy2;

  assign mat_ready      = rdy1;
  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_word_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        b1_p_nxt[r][c] = mul_ss(mat_word.m[r][c], mat_word.v[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      b2_s_nxt[r] = acc_t'(b1_p_r[r][0]) + acc_t'(b1_p_r[r][1]) + acc_t'(b1_p_r[r][2]);
    end
  end

  always_comb begin
    out_word_nxt.rot_x = round_sat(b2_s_r[0]);
    out_word_nxt.rot_y = round_sat(b2_s_r[1]);
    out_word_nxt.rot_z = round_sat(b2_s_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        b1_v_r <= mat_valid;
      end
      if (rdy2) begin
        b2_v_r <= b1_v_r;
      end
      if (rdy3) begin
        out_v_r <= b2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && mat_valid) begin
      b1_p_r <= b1_p_nxt;
    end
    if (rdy2 && b1_v_r) begin
      b2_s_r <= b2_s_nxt;
    end
    if (rdy3 && b2_v_r) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

// ----- hdl/quaternion_vector_rotate_unit.sv -----
// quaternion_vector_rotate_unit: top level of the quaternion vector rotate block
// depends on qvr_pkg, qvr_ifs, qvr_front, qvr_queue and qvr_back

// Rotates a q16.16 vector by a q1.30 quaternion through the standard unit-quaternion
// matrix; products round to nearest (ties up), matrix elements clamp to +-1.0 and
// results saturate to 32 bits. The block takes one word per clock while the input
// side is not stalled and returns one result word per input word, in order. With no
// stalls, result valid rises after seven register stages: three front stages
// (nine 32x32 products, rounding, matrix build), one in the 4-entry queue and three
// back stages (nine 32x32 products, row sums, round and saturate). Throughput is set by
// the 18 multipliers, each used once per word. The input side stalls only when the
// queue and the front stages are full, and the result side holds its word in the
// output register until it is taken.

module quaternion_vector_rotate_unit (
  input  logic       clk,
  input  logic       rst_n,
  qvr_in_if.sink     in_chan,
  qvr_out_if.source  out_chan
);
  import qvr_pkg::*;

  logic       f_valid, f_ready;
  qvr_mat_t   f_word;
  logic       b_valid, b_ready;
  qvr_mat_t   b_word;
  qvr_qstat_t q_stat;

  qvr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .mat_valid (f_valid),
    .mat_ready (f_ready),
    .mat_word  (f_word)
  );

  qvr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_word   (b_word),
    .stat       (q_stat)
  );

  qvr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_valid (b_valid),
    .mat_ready (b_ready),
    .mat_word  (b_word),
    .out_chan  (out_chan)
  );

`ifndef SYNTHESIS
  a_q_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QCNT_W'(QDEPTH))
    else $error("queue level beyond depth");

  a_q_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.pop |-> (q_stat.level != '0))
    else $error("queue pop while empty");

  a_q_level_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.push && !q_stat.pop) |=> (q_stat.level == $past(q_stat.level) + QCNT_W'(1)))
    else $error("queue level not tracking push");

  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_chan.valid && (q_stat.level == '0)))
    else $error("result word or queue entry survives reset");
`endif

endmodule

// ----- tb/sv/qvr_rotate_checker.sv -----
// qvr_rotate_checker: watches the input and result channels of the rotate unit,
// predicts each rotated vector and compares it field by field with the block's words
// depends on qvr_pkg and the qvr_in_if / qvr_out_if channel interfaces

module qvr_rotate_checker (
  input  logic clk,
  input  logic rst_n,
  qvr_in_if    in_mon,
  qvr_out_if   out_mon,
  output int   n_fail,
  output int   n_pending
);
  import qvr_pkg::*;

  typedef logic signed [79:0] wide_t;

  localparam wide_t Q30_ONE   = wide_t'(1) <<< 30;
  localparam wide_t PROD_HALF = wide_t'(1) <<< 28;
  localparam wide_t ROT_HALF  = wide_t'(1) <<< 29;
  localparam wide_t ROT_MAX   = (wide_t'(1) <<< 31) - wide_t'(1);
  localparam wide_t ROT_MIN   = -(wide_t'(1) <<< 31);

  qvr_out_t expected_rot[$];
  int       fail_cnt = 0;
  string    field_name[3] = '{"rot_x", "rot_y", "rot_z"};

  // 2ab in q1.30, round half up
  function automatic wide_t twice_prod(word_t a, word_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b) + PROD_HALF;
    return p >>> 29;
  endfunction

  function automatic wide_t unit_clamp(wide_t s);
    if (s > Q30_ONE) begin
      return Q30_ONE;
    end else if (s < -Q30_ONE) begin
      return -Q30_ONE;
    end
    return s;
  endfunction

  function automatic word_t row_dot(wide_t m0, wide_t m1, wide_t m2, qvr_in_t it);
    wide_t s;
    s = m0 * wide_t'(it.vec_x) + m1 * wide_t'(it.vec_y) + m2 * wide_t'(it.vec_z);
    s = (s + ROT_HALF) >>> 30;
    if (s > ROT_MAX) begin
      s = ROT_MAX;
    end else if (s < ROT_MIN) begin
      s = ROT_MIN;
    end
    return word_t'(s);
  endfunction

  function automatic qvr_out_t rotate_vector(qvr_in_t it);
    wide_t    xx, yy, zz, xy, xz, yz, wx, wy, wz;
    qvr_out_t r;
    xx = twice_prod(it.quat_x, it.quat_x);
    yy = twice_prod(it.quat_y, it.quat_y);
    zz = twice_prod(it.quat_z, it.quat_z);
    xy = twice_prod(it.quat_x, it.quat_y);
    xz = twice_prod(it.quat_x, it.quat_z);
    yz = twice_prod(it.quat_y, it.quat_z);
    wx = twice_prod(it.quat_w, it.quat_x);
    wy = twice_prod(it.quat_w, it.quat_y);
    wz = twice_prod(it.quat_w, it.quat_z);
    r.rot_x = row_dot(unit_clamp(Q30_ONE - (yy + zz)), unit_clamp(xy - wz),
                      unit_clamp(xz + wy), it);
    r.rot_y = row_dot(unit_clamp(xy + wz), unit_clamp(Q30_ONE - (xx + zz)),
                      unit_clamp(yz - wx), it);
    r.rot_z = row_dot(unit_clamp(xz - wy), unit_clamp(yz + wx),
                      unit_clamp(Q30_ONE - (xx + yy)), it);
    return r;
  endfunction

  always @(posedge clk) begin
    qvr_out_t want;
    qvr_out_t got;
    word_t    want_f[3];
    word_t    got_f[3];
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_rot.size() == 0) begin
          $display("%0t: result word with none expected: %h", $time, got);
          fail_cnt++;
        end else begin
          want = expected_rot.pop_front();
          want_f = '{want.rot_x, want.rot_y, want.rot_z};
          got_f = '{got.rot_x, got.rot_y, got.rot_z};
          for (int k = 0; k < 3; k++) begin
            if (want_f[k] !== got_f[k]) begin
              $display("%0t: %s expected %0d (%h) actual %0d (%h)", $time, field_name[k],
                       want_f[k], want_f[k], got_f[k], got_f[k]);
              fail_cnt++;
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_rot.push_back(rotate_vector(in_mon.data));
      end
    end
    n_fail <= fail_cnt;
    n_pending <= expected_rot.size();
  end

endmodule

// ----- tb/sv/tb_quaternion_vector_rotate_unit.sv -----
// tb_quaternion_vector_rotate_unit: stimulus and verdict for the quaternion vector rotate unit
// drives directed and random words in bursts, stalls the result side, checks via qvr_rotate_checker
// depends on qvr_pkg, qvr_ifs, qvr_rotate_checker and quaternion_vector_rotate_unit

module tb_quaternion_vector_rotate_unit;
  import qvr_pkg::*;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  localparam int          N_RANDOM    = 950;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_STEP   = 480;

  localparam word_t Q_ONE  = 32'sh4000_0000;
  localparam word_t Q_HALF = 32'sh2000_0000;
  localparam word_t Q_R2   = 32'sd759250125;
  localparam word_t Q_C22  = 32'sd992008094;
  localparam word_t Q_S22  = 32'sd410903207;
  localparam word_t W_MAX  = 32'sh7fff_ffff;
  localparam word_t W_MIN  = 32'sh8000_0000;
  localparam word_t V_ONE  = 32'sh0001_0000;

  logic        clk;
  logic        rst_n;
  int          n_fail;
  int          n_pending;
  int          burst_left = 0;
  int unsigned n_cycles = 0;

  qvr_in_if  in_chan ();
  qvr_out_if out_chan ();

  quaternion_vector_rotate_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  qvr_rotate_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic qvr_in_t make_word(word_t w, word_t x, word_t y, word_t z,
                                        word_t vx, word_t vy, word_t vz);
    qvr_in_t it;
    it = '{quat_w: w, quat_x: x, quat_y: y, quat_z: z, vec_x: vx, vec_y: vy, vec_z: vz};
    return it;
  endfunction

  function automatic word_t axis_part();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return Q_ONE;
      2: return -Q_ONE;
      3: return Q_HALF;
      default: return -Q_HALF;
    endcase
  endfunction

  function automatic word_t in_range_part();
    return word_t'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
  endfunction

  function automatic qvr_in_t random_word();
    qvr_in_t it;
    real     r[4];
    real     norm;
    int      kind;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) begin
      it.vec_x = $urandom;
      it.vec_y = $urandom;
      it.vec_z = $urandom;
    end else begin
      it.vec_x = word_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      it.vec_y = word_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      it.vec_z = word_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    end
    if (kind < 45) begin
      // true rotations
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
        r[k] = real'(int'($urandom_range(0, 2000000)) - 1000000);
        norm += r[k] * r[k];
      end
      norm = $sqrt(norm);
      if (norm < 1.0) begin
        it.quat_w = Q_ONE;
        it.quat_x = '0;
        it.quat_y = '0;
        it.quat_z = '0;
      end else begin
        it.quat_w = word_t'($rtoi(r[0] / norm * 1073741824.0));
        it.quat_x = word_t'($rtoi(r[1] / norm * 1073741824.0));
        it.quat_y = word_t'($rtoi(r[2] / norm * 1073741824.0));
        it.quat_z = word_t'($rtoi(r[3] / norm * 1073741824.0));
      end
    end else if (kind < 65) begin
      it.quat_w = in_range_part();
      it.quat_x = in_range_part();
      it.quat_y = in_range_part();
      it.quat_z = in_range_part();
    end else if (kind < 80) begin
      it.quat_w = $urandom;
      it.quat_x = $urandom;
      it.quat_y = $urandom;
      it.quat_z = $urandom;
    end else if (kind < 92) begin
      it.quat_w = axis_part();
      it.quat_x = axis_part();
      it.quat_y = axis_part();
      it.quat_z = axis_part();
    end else begin
      // tiny parts, products land near the rounding point
      it.quat_w = word_t'(int'($urandom_range(0, 65536)) - 32768);
      it.quat_x = word_t'(int'($urandom_range(0, 65536)) - 32768);
      it.quat_y = word_t'(int'($urandom_range(0, 65536)) - 32768);
      it.quat_z = word_t'(int'($urandom_range(0, 65536)) - 32768);
    end
    return it;
  endfunction

  // call right after a rising edge; returns right after the edge that takes the word
  task automatic offer_word(input qvr_in_t word_in);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.data <= word_in;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_directed();
    offer_word(make_word(Q_ONE, '0, '0, '0, V_ONE, 2 * V_ONE, 3 * V_ONE));
    offer_word(make_word(Q_ONE, '0, '0, '0, W_MAX, W_MIN, '0));
    offer_word(make_word('0, '0, '0, '0, W_MIN, W_MAX, -1));
    offer_word(make_word(-Q_ONE, '0, '0, '0, W_MAX, W_MAX, W_MAX));
    offer_word(make_word(Q_R2, Q_R2, '0, '0, V_ONE, V_ONE, V_ONE));
    offer_word(make_word(Q_R2, '0, Q_R2, '0, V_ONE, -V_ONE, V_ONE));
    offer_word(make_word(Q_R2, '0, '0, Q_R2, V_ONE, 2 * V_ONE, -V_ONE));
    offer_word(make_word('0, Q_ONE, '0, '0, W_MAX, W_MIN, 5));
    offer_word(make_word('0, '0, Q_ONE, '0, W_MIN, 7, W_MAX));
    offer_word(make_word('0, '0, '0, Q_ONE, -3, W_MAX, W_MIN));
    offer_word(make_word(Q_HALF, Q_HALF, Q_HALF, Q_HALF, W_MAX, 1, -1));
    offer_word(make_word(-Q_HALF, -Q_HALF, -Q_HALF, -Q_HALF, V_ONE, W_MIN, 0));
    // 45 degrees about z, output saturates
    offer_word(make_word(Q_C22, '0, '0, Q_S22, W_MAX, W_MAX, '0));
    offer_word(make_word(Q_C22, '0, '0, Q_S22, W_MIN, W_MIN, '0));
    // non-unit and out of range quaternions
    offer_word(make_word(Q_ONE, Q_ONE, Q_ONE, Q_ONE, W_MAX, W_MIN, W_MAX));
    offer_word(make_word(W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MIN));
    offer_word(make_word(W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX, W_MAX));
    offer_word(make_word(W_MIN, W_MAX, -Q_ONE, Q_ONE, V_ONE, V_ONE, V_ONE));
    // product rounding ties
    offer_word(make_word(Q_ONE, 16384, -16384, 16384, 3, -5, 7));
    // result rounding ties
    offer_word(make_word('0, '0, Q_HALF, '0, 1, '0, '0));
    offer_word(make_word('0, '0, Q_HALF, '0, -1, '0, '0));
    offer_word(make_word('0, '0, Q_HALF, '0, 3, -3, 1));
  endtask

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    for (int i = 0; i < N_RANDOM; i++) begin
      offer_word(random_word());
    end
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side: random stall patterns plus long hold-offs that back the block up
  initial begin
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    int       n_taken;
    int       next_hold;
    mode = RX_OPEN;
    seg_left = 0;
    hold_left = 0;
    n_taken = 0;
    next_hold = 120;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_chan.valid && out_chan.ready) begin
        n_taken++;
      end
      if (hold_left == 0 && n_taken >= next_hold) begin
        hold_left = $urandom_range(80, 150);
        next_hold += HOLD_STEP;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (mode)
          RX_OPEN: out_chan.ready <= 1'b1;
          RX_HALF: out_chan.ready <= ($urandom_range(0, 1) == 0);
          RX_SPARSE: out_chan.ready <= ($urandom_range(0, 3) == 0);
          default: out_chan.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

endmodule
